@@ rtl/core/sorted_list_adjust_reposition_top_defines.svh @@
// ----------------------------------------------------------------------------
// sorted_list_adjust_reposition_top_defines
// Assertion macros for the sorted list block, clocked on clk_i and disabled
// while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_ADJUST_REPOSITION_TOP_DEFINES_SVH
`define SORTED_LIST_ADJUST_REPOSITION_TOP_DEFINES_SVH
`ifndef SYNTH
`define SLAR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("sorted list assertion failed");
`define SLAR_ASSERT_NEXT(lbl, ante, cons) \
  `SLAR_ASSERT(lbl, ante |=> cons)
`else
`define SLAR_ASSERT(lbl, prop)
`define SLAR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/core/slar_pkg.sv @@
// ----------------------------------------------------------------------------
// slar_pkg
// Shared constants and types of the sorted list adjust block.
// ----------------------------------------------------------------------------
`default_nettype none

package slar_pkg;

  localparam int unsigned SLAR_MAX_ENTRIES = 32;
  localparam int unsigned SLAR_VALUE_BITS  = 32;

  localparam int unsigned FIELD_W  = 32;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned STATUS_W = 2;

  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_ADJUST = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic gt;
    logic lt;
  } slar_cmp_t;

endpackage

`default_nettype wire

@@ rtl/core/slar_if.sv @@
// ----------------------------------------------------------------------------
// slar_if
// Request and response channels of the sorted list adjust block.
// ----------------------------------------------------------------------------
`default_nettype none

interface slar_req_if import slar_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [OP_W-1:0]            op;
  logic signed [FIELD_W-1:0]  value;
  logic [POS_W-1:0]           position;
  logic signed [FIELD_W-1:0]  delta;

  modport source (output valid, op, value, position, delta, input ready);
  modport sink   (input valid, op, value, position, delta, output ready);
endinterface

interface slar_rsp_if import slar_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [FIELD_W-1:0]  item;
  logic [POS_W-1:0]           slot;
  logic                       last;
  logic [STATUS_W-1:0]        status;

  modport source (output valid, item, slot, last, status, input ready);
  modport sink   (input valid, item, slot, last, status, output ready);
endinterface

`default_nettype wire

@@ rtl/core/slar_alu.sv @@
// ----------------------------------------------------------------------------
// slar_alu
// Shared adder and signed comparator used by the fetch and walk steps of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module slar_alu import slar_pkg::*; #(
  parameter int unsigned VALUE_BITS = SLAR_VALUE_BITS
) (
  input  logic [VALUE_BITS-1:0] a_i,
  input  logic [VALUE_BITS-1:0] b_i,
  output logic [VALUE_BITS-1:0] sum_o,
  output slar_cmp_t             cmp_o
);

  // sum wraps at the value width
  assign sum_o    = a_i + b_i;
  assign cmp_o.gt = $signed(a_i) > $signed(b_i);
  assign cmp_o.lt = $signed(a_i) < $signed(b_i);

endmodule

`default_nettype wire

@@ rtl/core/sorted_list_adjust_reposition_top.sv @@
// ----------------------------------------------------------------------------
// sorted_list_adjust_reposition_top
// Bounded ordered list with append, clear and adjust-and-reposition.
// ----------------------------------------------------------------------------
//  channel  dir  payload                           transfer
//  req_i    in   op, value, position, delta        valid && ready
//  rsp_o    out  item, slot, last, status          valid && ready
//
//  append, clear and a rejected adjust complete in idle.
//  an adjust fetches the entry and adds delta, then walks it with c compare
//  steps (entries moved past, plus one for each walk that ends on a
//  neighbour; at most n - 1 for a list of n entries), writes it and emits
//  all n entries, paced by the single memory read port and shared comparator.
//  after reset the list is empty; the entry memory is not cleared.
//  a stalled response holds the sequencer; requests wait while it is busy.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sorted_list_adjust_reposition_top_defines.svh"

module sorted_list_adjust_reposition_top import slar_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = SLAR_MAX_ENTRIES,
  parameter int unsigned VALUE_BITS  = SLAR_VALUE_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  slar_req_if.sink    req_i,
  slar_rsp_if.source  rsp_o
);

  localparam int unsigned AW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned XW = CW + 1;
  localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FETCH = 6'b000010,
    S_UP    = 6'b000100,
    S_DOWN  = 6'b001000,
    S_WRITE = 6'b010000,
    S_EMIT  = 6'b100000
  } state_e;

  function automatic logic [FIELD_W-1:0] item_of(input logic [VALUE_BITS-1:0] v);
    item_of = FIELD_W'(v);
  endfunction

  state_e                state_q, state_d;
  logic [CW-1:0]         count_q, count_d;
  logic [AW-1:0]         pos_q, pos_d;
  logic [AW-1:0]         p_q, p_d;
  logic [VALUE_BITS-1:0] delta_q, delta_d;
  logic [VALUE_BITS-1:0] v_q, v_d;
  logic [CW-1:0]         e_iss_q, e_iss_d;
  logic [CW-1:0]         e_out_q, e_out_d;
  logic                  pend_q, pend_d;

  // entry memory
  logic [VALUE_BITS-1:0] mem_q [MAX_ENTRIES];
  logic [VALUE_BITS-1:0] rdata_q;
  logic                  we, ren;
  logic [AW-1:0]         waddr, raddr;
  logic [VALUE_BITS-1:0] wdata;

  // response register
  logic                  out_valid_q;
  logic [FIELD_W-1:0]    out_item_q;
  logic [POS_W-1:0]      out_slot_q;
  logic                  out_last_q;
  logic [STATUS_W-1:0]   out_status_q;
  logic                  out_load;
  logic [FIELD_W-1:0]    ld_item;
  logic [POS_W-1:0]      ld_slot;
  logic                  ld_last;
  logic [STATUS_W-1:0]   ld_status;
  logic                  out_free;

  logic [VALUE_BITS-1:0] val_ext, dlt_ext;
  logic [VALUE_BITS-1:0] alu_b, alu_sum;
  slar_cmp_t             alu_cmp;
  logic                  consume, issue;

  assign val_ext = VALUE_BITS'(req_i.value);
  assign dlt_ext = VALUE_BITS'(req_i.delta);

  assign alu_b = (state_q == S_FETCH) ? delta_q : v_q;

  slar_alu #(
    .VALUE_BITS (VALUE_BITS)
  ) u_alu (
    .a_i   (rdata_q),
    .b_i   (alu_b),
    .sum_o (alu_sum),
    .cmp_o (alu_cmp)
  );

  assign out_free    = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == S_IDLE) && out_free;

  assign consume = (state_q == S_EMIT) && pend_q && out_free;
  assign issue   = (state_q == S_EMIT) && (e_iss_q < count_q) && (!pend_q || consume);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    pos_d     = pos_q;
    p_d       = p_q;
    delta_d   = delta_q;
    v_d       = v_q;
    e_iss_d   = e_iss_q;
    e_out_d   = e_out_q;
    pend_d    = pend_q;
    we        = 1'b0;
    waddr     = '0;
    wdata     = '0;
    ren       = 1'b0;
    raddr     = '0;
    out_load  = 1'b0;
    ld_item   = '0;
    ld_slot   = '0;
    ld_last   = 1'b0;
    ld_status = ST_OK;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid && req_i.ready) begin
          case (req_i.op)
            OP_APPEND: begin
              out_load = 1'b1;
              ld_item  = item_of(val_ext);
              ld_last  = 1'b1;
              if (count_q == CW'(MAX_ENTRIES)) begin
                ld_status = ST_FULL;
              end else begin
                we      = 1'b1;
                waddr   = count_q[AW-1:0];
                wdata   = val_ext;
                ld_slot = POS_W'(count_q);
                count_d = count_q + 1'b1;
              end
            end
            OP_ADJUST: begin
              if (PW'(req_i.position) >= PW'(count_q)) begin
                out_load  = 1'b1;
                ld_slot   = req_i.position;
                ld_last   = 1'b1;
                ld_status = ST_RANGE;
              end else begin
                pos_d   = AW'(req_i.position);
                p_d     = AW'(req_i.position);
                delta_d = dlt_ext;
                ren     = 1'b1;
                raddr   = AW'(req_i.position);
                state_d = S_FETCH;
              end
            end
            OP_CLEAR: count_d = '0;
            default: ;
          endcase
        end
      end
      S_FETCH: begin
        v_d = alu_sum;
        if (pos_q != '0) begin
          ren     = 1'b1;
          raddr   = pos_q - 1'b1;
          state_d = S_UP;
        end else if (XW'(pos_q) + 1'b1 < XW'(count_q)) begin
          ren     = 1'b1;
          raddr   = pos_q + 1'b1;
          state_d = S_DOWN;
        end else begin
          state_d = S_WRITE;
        end
      end
      S_UP: begin
        // rdata holds the entry just above p
        if (alu_cmp.gt) begin
          we    = 1'b1;
          waddr = p_q;
          wdata = rdata_q;
          p_d   = p_q - 1'b1;
          if (XW'(p_q) > XW'(1)) begin
            ren   = 1'b1;
            raddr = p_q - 1'b1 - 1'b1;
          end else begin
            state_d = S_WRITE;
          end
        end else if (p_q == pos_q && XW'(pos_q) + 1'b1 < XW'(count_q)) begin
          // did not move up, try toward the tail
          ren     = 1'b1;
          raddr   = pos_q + 1'b1;
          state_d = S_DOWN;
        end else begin
          state_d = S_WRITE;
        end
      end
      S_DOWN: begin
        if (alu_cmp.lt) begin
          we    = 1'b1;
          waddr = p_q;
          wdata = rdata_q;
          p_d   = p_q + 1'b1;
          if (XW'(p_q) + XW'(2) < XW'(count_q)) begin
            ren   = 1'b1;
            raddr = p_q + 1'b1 + 1'b1;
          end else begin
            state_d = S_WRITE;
          end
        end else begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        we      = 1'b1;
        waddr   = p_q;
        wdata   = v_q;
        e_iss_d = '0;
        e_out_d = '0;
        pend_d  = 1'b0;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (issue) begin
          ren     = 1'b1;
          raddr   = e_iss_q[AW-1:0];
          e_iss_d = e_iss_q + 1'b1;
        end
        if (consume) begin
          out_load = 1'b1;
          ld_item  = item_of(rdata_q);
          ld_slot  = POS_W'(e_out_q);
          ld_last  = (e_out_q + 1'b1) == count_q;
          e_out_d  = e_out_q + 1'b1;
          if (ld_last) begin
            state_d = S_IDLE;
          end
        end
        pend_d = issue || (pend_q && !consume);
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      e_iss_q     <= '0;
      e_out_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      e_iss_q <= e_iss_d;
      e_out_q <= e_out_d;
      pend_q  <= pend_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    p_q     <= p_d;
    delta_q <= delta_d;
    v_q     <= v_d;
    if (out_load) begin
      out_item_q   <= ld_item;
      out_slot_q   <= ld_slot;
      out_last_q   <= ld_last;
      out_status_q <= ld_status;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ren) begin
      rdata_q <= mem_q[raddr];
    end
  end

  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.item   = out_item_q;
  assign rsp_o.slot   = out_slot_q;
  assign rsp_o.last   = out_last_q;
  assign rsp_o.status = out_status_q;

  `SLAR_ASSERT(a_count_bound, XW'(count_q) <= XW'(MAX_ENTRIES))
  `SLAR_ASSERT(a_up_above_pos, (state_q == S_UP) |-> (p_q <= pos_q))
  `SLAR_ASSERT(a_down_in_list, (state_q == S_DOWN) |-> (XW'(p_q) + 1'b1 < XW'(count_q)))
  `SLAR_ASSERT(a_pend_order, pend_q |-> (e_out_q < e_iss_q))
  `SLAR_ASSERT_NEXT(a_last_ends_run, consume && ld_last, state_q == S_IDLE)

endmodule

`default_nettype wire

@@ bench/slar_list_scoreboard_pkg.sv @@
// ----------------------------------------------------------------------------
// slar_list_scoreboard_pkg
// Expected-beat bookkeeping for the sorted list adjust block: keeps its own
// copy of the list, predicts the beats each accepted request causes and
// compares them in order against the beats the block returns.
// ----------------------------------------------------------------------------
package slar_list_scoreboard_pkg;
  import slar_pkg::*;

  typedef struct packed {
    logic signed [FIELD_W-1:0] item;
    logic [POS_W-1:0]          slot;
    logic                      last;
    logic [STATUS_W-1:0]       status;
  } list_beat_t;

  class list_scoreboard;
    logic signed [FIELD_W-1:0] entries [SLAR_MAX_ENTRIES];
    int unsigned               list_len;
    list_beat_t                expected_beats [$];
    int unsigned               mismatches;

    function new();
      list_len   = 0;
      mismatches = 0;
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask

    function void add_beat(list_beat_t beat);
      expected_beats = {expected_beats, beat};
    endfunction

    // update the list copy and queue the beats this request will cause
    function void note_request(logic [OP_W-1:0] op, logic signed [FIELD_W-1:0] value,
                               logic [POS_W-1:0] position,
                               logic signed [FIELD_W-1:0] delta);
      logic signed [FIELD_W-1:0] moved;
      int unsigned               at;
      case (op)
        OP_APPEND: begin
          if (list_len >= SLAR_MAX_ENTRIES) begin
            add_beat('{item: value, slot: '0, last: 1'b1, status: ST_FULL});
          end else begin
            entries[list_len] = value;
            add_beat('{item: value, slot: POS_W'(list_len), last: 1'b1, status: ST_OK});
            list_len++;
          end
        end
        OP_CLEAR: begin
          list_len = 0;
        end
        OP_ADJUST: begin
          if (position >= list_len) begin
            add_beat('{item: '0, slot: position, last: 1'b1, status: ST_RANGE});
          end else begin
            moved = entries[position] + delta;
            at    = position;
            // head-ward past strictly larger, else tail-ward past strictly smaller
            while (at > 0 && entries[at-1] > moved) begin
              entries[at] = entries[at-1];
              at--;
            end
            if (at == position) begin
              while (at + 1 < list_len && entries[at+1] < moved) begin
                entries[at] = entries[at+1];
                at++;
              end
            end
            entries[at] = moved;
            for (int i = 0; i < list_len; i++) begin
              add_beat('{item: entries[i], slot: POS_W'(i),
                         last: (i + 1 == list_len), status: ST_OK});
            end
          end
        end
        default: ;
      endcase
    endfunction

    task check_response(logic signed [FIELD_W-1:0] item, logic [POS_W-1:0] slot,
                        logic last, logic [STATUS_W-1:0] status);
      list_beat_t want;
      if (expected_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected beat item %0d slot %0d status %0d",
                                  item, slot, status));
        return;
      end
      want = expected_beats[0];
      expected_beats.delete(0);
      if (item !== want.item)
        report_mismatch($sformatf("item %0d, want %0d", item, want.item));
      if (slot !== want.slot)
        report_mismatch($sformatf("slot %0d, want %0d", slot, want.slot));
      if (last !== want.last)
        report_mismatch($sformatf("last %b, want %b", last, want.last));
      if (status !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", status, want.status));
    endtask
  endclass

endpackage

@@ bench/sorted_list_adjust_reposition_top_test.sv @@
// ----------------------------------------------------------------------------
// sorted_list_adjust_reposition_top_test
// Drives appends, adjusts, clears and ignored codes into the sorted list
// block under several sender/receiver throttling mixes, predicts every
// response beat from a private copy of the list and checks them in order.
// ----------------------------------------------------------------------------
module sorted_list_adjust_reposition_top_test
  import slar_pkg::*, slar_list_scoreboard_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned PHASE_ITEMS  = 72;
  localparam logic signed [FIELD_W-1:0] VAL_MAX = 32'sh7fffffff;
  localparam logic signed [FIELD_W-1:0] VAL_MIN = 32'sh80000000;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic clk_i;
  logic rst_ni;

  slar_req_if req_if ();
  slar_rsp_if rsp_if ();

  sorted_list_adjust_reposition_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  list_scoreboard scoreboard = new();

  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned items_sent;
  int unsigned cycle_count;

  initial begin
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    req_if.valid    = 1'b0;
    req_if.op       = OP_APPEND;
    req_if.value    = '0;
    req_if.position = '0;
    req_if.delta    = '0;
    rsp_if.ready    = 1'b0;
    idle_pct        = 0;
    stall_pct       = 0;
    items_sent      = 0;
    cycle_count     = 0;
  end

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("sorted_list_adjust_reposition_top verification failed");
    $finish;
  end

  // response side: check each transfer, then decide on a stall
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      scoreboard.check_response(rsp_if.item, rsp_if.slot, rsp_if.last, rsp_if.status);
    end
    rsp_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // valid stays high after a transfer; the next call or a drain settles it
  task automatic send_request(input logic [OP_W-1:0] op,
                              input logic signed [FIELD_W-1:0] value,
                              input logic [POS_W-1:0] position,
                              input logic signed [FIELD_W-1:0] delta);
    while ($urandom_range(99) < idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.op       <= op;
    req_if.value    <= value;
    req_if.position <= position;
    req_if.delta    <= delta;
    do @(posedge clk_i); while (!req_if.ready);
    scoreboard.note_request(op, value, position, delta);
    if (op != OP_UNUSED) items_sent++;
  endtask

  task automatic drain_results();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (scoreboard.expected_beats.size() != 0);
  endtask

  function automatic logic signed [FIELD_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2, 3, 4: return $urandom_range(16) - 8;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic signed [FIELD_W-1:0] pick_delta(int unsigned position);
    int unsigned other;
    case ($urandom_range(9))
      0:       return '0;
      1:       return 1;
      2:       return -1;
      3:       return VAL_MIN;
      4:       return VAL_MAX;
      5, 6:    return $urandom_range(32) - 16;
      7:       return $urandom();
      default: begin
        // land exactly on another entry's value to exercise ties
        other = $urandom_range(scoreboard.list_len - 1);
        return scoreboard.entries[other] - scoreboard.entries[position];
      end
    endcase
  endfunction

  task automatic adjust_random_entry();
    int unsigned pos;
    pos = $urandom_range(scoreboard.list_len - 1);
    send_request(OP_ADJUST, $urandom(), POS_W'(pos), pick_delta(pos));
  endtask

  // clear, fill to a random length, then a handful of adjusts and noise
  task automatic run_list_session();
    int unsigned fill;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: fill = $urandom_range(8, 1);
      5, 6, 7:       fill = $urandom_range(20, 9);
      8:             fill = $urandom_range(32, 28);
      default:       fill = SLAR_MAX_ENTRIES + 2;
    endcase
    send_request(OP_CLEAR, $urandom(), POS_W'($urandom()), $urandom());
    repeat (fill) send_request(OP_APPEND, pick_value(), POS_W'($urandom()), $urandom());
    repeat ($urandom_range(6, 2)) begin
      case ($urandom_range(19))
        0:       send_request(OP_UNUSED, $urandom(), POS_W'($urandom()), $urandom());
        1:       send_request(OP_ADJUST, $urandom(), POS_W'($urandom()), $urandom());
        2:       send_request(OP_APPEND, pick_value(), POS_W'($urandom()), $urandom());
        3:       send_request(OP_ADJUST, $urandom(), POS_W'(scoreboard.list_len), $urandom());
        default: adjust_random_entry();
      endcase
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty list, extremes, wraparound, ties and range errors
    send_request(OP_ADJUST, '0, 5'd0, 32'sd3);
    send_request(OP_CLEAR, '0, '0, '0);
    send_request(OP_UNUSED, '1, '1, '1);
    send_request(OP_APPEND, VAL_MAX, '0, '0);
    send_request(OP_APPEND, VAL_MIN, '1, '1);
    send_request(OP_APPEND, '0, '0, '0);
    send_request(OP_APPEND, -1, '0, '0);
    send_request(OP_APPEND, 32'sd5, '0, '0);
    send_request(OP_APPEND, 32'sd5, '0, '0);
    send_request(OP_APPEND, 32'sd5, '0, '0);
    send_request(OP_ADJUST, '0, 5'd1, '0);
    send_request(OP_ADJUST, '0, 5'd1, 32'sd1);
    send_request(OP_ADJUST, '0, 5'd2, '0);
    send_request(OP_ADJUST, '0, 5'd4, '0);
    send_request(OP_ADJUST, '0, 5'd0, -1);
    send_request(OP_ADJUST, '0, 5'd6, VAL_MIN);
    send_request(OP_ADJUST, '0, 5'd7, '0);
    send_request(OP_ADJUST, '1, 5'd31, VAL_MAX);
    send_request(OP_ADJUST, '0, 5'd3, 32'sd2);
    send_request(OP_CLEAR, '0, '0, '0);
    send_request(OP_APPEND, 32'sd42, '0, '0);
    send_request(OP_ADJUST, '0, 5'd0, -32'sd100);
    drain_results();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 54; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 54; end
        default: begin idle_pct = 18; stall_pct = 18; end
      endcase
      items_sent = 0;
      while (items_sent < PHASE_ITEMS / 2) run_list_session();
      // hold off until the block has answered everything
      drain_results();
      while (items_sent < PHASE_ITEMS) run_list_session();
      drain_results();
    end

    repeat (2 * SLAR_MAX_ENTRIES + 16) @(posedge clk_i);
    if (scoreboard.expected_beats.size() != 0) begin
      scoreboard.report_mismatch($sformatf("%0d beats never arrived",
                                           scoreboard.expected_beats.size()));
    end
    if (scoreboard.mismatches == 0) begin
      $display("sorted_list_adjust_reposition_top verification clean");
    end else begin
      $display("sorted_list_adjust_reposition_top verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/slar_pkg.sv
rtl/core/slar_if.sv
rtl/core/slar_alu.sv
rtl/core/sorted_list_adjust_reposition_top.sv
bench/slar_list_scoreboard_pkg.sv
bench/sorted_list_adjust_reposition_top_test.sv
